// ===== design/cbt_pkg.sv =====
// Shared types and constants for the counted binary trie max-XOR block.
// Used by the front queue, the trie engine and the top level.
// Depends on nothing.
package cbt_pkg;

	// Field widths fixed by the stream format.
	localparam int OP_W    = 2;
	localparam int KEY_W   = 31;
	localparam int XOR_W   = 31;
	localparam int STAT_W  = 2;
	localparam int TDATA_W = 40;
	localparam int COUNT_W = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// Operation codes carried in the input transaction.
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_CLEAR  = 2'd3
	} op_e_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2,
		ST_EMPTY  = 2'd3
	} status_e_t;

	// One queued operation.
	typedef struct packed {
		op_e_t             op;
		logic [KEY_W-1:0]  key;
	} item_t;

endpackage

// ===== design/cbt_front.sv =====
// Front end: accepts input transactions, decodes the operation code and
// holds them in a two-entry queue for the trie engine. Uses cbt_pkg.
module cbt_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cbt_pkg::TDATA_W-1:0]   s_tdata,
	output logic                          q_valid,
	input  logic                          q_pop,
	output cbt_pkg::item_t                q_item
);

	cbt_pkg::item_t   mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	cbt_pkg::item_t   in_item;

	// Split the transaction into operation and key.
	assign in_item.op  = cbt_pkg::op_e_t'(s_tdata[cbt_pkg::OP_W-1:0]);
	assign in_item.key = s_tdata[cbt_pkg::OP_W +: cbt_pkg::KEY_W];

	assign s_tready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign push     = s_tvalid && s_tready;
	assign q_item   = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// ===== design/cbt_engine.sv =====
// Back end: walks the trie held in node memories, one level per cycle for insert
// and delete, and drives the result register. Uses cbt_pkg.
module cbt_engine #(
	parameter int NODE_POOL = 32768,
	parameter int KEY_BITS  = 31
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  cbt_pkg::item_t                q_item,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cbt_pkg::TDATA_W-1:0]   m_tdata
);

	localparam int NODE_W = $clog2(NODE_POOL);
	localparam int USED_W = NODE_W + 1;
	localparam int SUM_W  = NODE_W + 2;
	localparam int DEP_W  = $clog2(KEY_BITS + 1);
	localparam int CW     = cbt_pkg::COUNT_W;

	typedef enum logic [5:0] {
		S_INIT  = 6'b000001,
		S_IDLE  = 6'b000010,
		S_WALK  = 6'b000100,
		S_ALLOC = 6'b001000,
		S_QWANT = 6'b010000,
		S_QB    = 6'b100000
	} state_t;

	// Node memories.
	logic [NODE_W-1:0] c0_mem [NODE_POOL];
	logic [NODE_W-1:0] c1_mem [NODE_POOL];
	logic [CW-1:0]     cnt_mem [NODE_POOL];

	logic              rd_en;
	logic [NODE_W-1:0] rd_addr;
	logic [NODE_W-1:0] c0_rd, c1_rd;
	logic [CW-1:0]     cnt_rd;
	logic              c0_we, c1_we, cnt_we;
	logic [NODE_W-1:0] c0_wa, c1_wa, cnt_wa, c0_wd, c1_wd;
	logic [CW-1:0]     cnt_wd;

	state_t              state_q, state_d;
	logic                pass_q, pass_d;
	cbt_pkg::op_e_t      op_q, op_d;
	logic [KEY_BITS-1:0] key_q, key_d, key_sh_q, key_sh_d, res_q, res_d;
	logic [DEP_W-1:0]    depth_q, depth_d;
	logic [NODE_W-1:0]   cur_q, cur_d, nb_q, nb_d;
	logic [USED_W-1:0]   used_q, used_d;
	logic                par_new_q, par_new_d;
	logic                out_valid_q;
	logic [cbt_pkg::XOR_W-1:0] out_xor_q;
	cbt_pkg::status_e_t  out_st_q;

	logic                fin;
	cbt_pkg::status_e_t  fin_st;
	logic [cbt_pkg::XOR_W-1:0] fin_xor;
	logic                bit_k, at_leaf, at_root;
	logic [NODE_W-1:0]   lk_b, lk_nb, new_node;
	logic [SUM_W-1:0]    need, total;

	// Memory write ports.
	always_ff @(posedge clk) begin
		if (c0_we) c0_mem[c0_wa] <= c0_wd;
		if (c1_we) c1_mem[c1_wa] <= c1_wd;
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
	end

	// Memory read port, registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			c0_rd  <= c0_mem[rd_addr];
			c1_rd  <= c1_mem[rd_addr];
			cnt_rd <= cnt_mem[rd_addr];
		end
	end

	assign bit_k    = key_sh_q[KEY_BITS-1];
	assign at_leaf  = (depth_q == DEP_W'(KEY_BITS));
	assign at_root  = (depth_q == '0);
	assign lk_b     = bit_k ? c1_rd : c0_rd;
	assign lk_nb    = bit_k ? c0_rd : c1_rd;
	assign new_node = used_q[NODE_W-1:0];
	assign need     = at_leaf ? '0 : (SUM_W'(KEY_BITS) - SUM_W'(depth_q));
	assign total    = SUM_W'(used_q) + need;

	// Sequencer for all four operations.
	always_comb begin
		state_d   = state_q;
		pass_d    = pass_q;
		op_d      = op_q;
		key_d     = key_q;
		key_sh_d  = key_sh_q;
		res_d     = res_q;
		depth_d   = depth_q;
		cur_d     = cur_q;
		nb_d      = nb_q;
		used_d    = used_q;
		par_new_d = par_new_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		c0_we = 1'b0; c0_wa = '0; c0_wd = '0;
		c1_we = 1'b0; c1_wa = '0; c1_wd = '0;
		cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0;
		q_pop   = 1'b0;
		fin     = 1'b0;
		fin_st  = cbt_pkg::ST_OK;
		fin_xor = '0;
		unique case (state_q)
			S_INIT: begin
				c0_we = 1'b1;
				c1_we = 1'b1;
				cnt_we = 1'b1;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (q_valid && (!out_valid_q || m_tready)) begin
					q_pop = 1'b1;
					op_d  = q_item.op;
					key_d = KEY_BITS'(q_item.key);
					if (q_item.op == cbt_pkg::OP_CLEAR) begin
						c0_we  = 1'b1;
						c1_we  = 1'b1;
						cnt_we = 1'b1;
						used_d = USED_W'(1);
						fin    = 1'b1;
					end else begin
						rd_en    = 1'b1;
						cur_d    = '0;
						depth_d  = '0;
						pass_d   = 1'b0;
						res_d    = '0;
						key_sh_d = KEY_BITS'(q_item.key);
						state_d  = S_WALK;
					end
				end
			end
			S_WALK: begin
				unique case (op_q)
					cbt_pkg::OP_INSERT: begin
						if (!pass_q) begin
							// Check pass: capacity of counts and of the pool.
							if (!at_root && cnt_rd == cbt_pkg::COUNT_MAX) begin
								fin = 1'b1;
								fin_st = cbt_pkg::ST_FULL;
							end else if (at_leaf || lk_b == '0) begin
								if (total > SUM_W'(NODE_POOL)) begin
									fin = 1'b1;
									fin_st = cbt_pkg::ST_FULL;
								end else begin
									pass_d = 1'b1;
									rd_en = 1'b1;
									cur_d = '0;
									depth_d = '0;
									key_sh_d = key_q;
								end
							end else begin
								rd_en = 1'b1;
								rd_addr = lk_b;
								cur_d = lk_b;
								depth_d = depth_q + DEP_W'(1);
								key_sh_d = key_sh_q << 1;
							end
						end else begin
							// Update pass: count up existing nodes, then allocate.
							if (!at_root) begin
								cnt_we = 1'b1;
								cnt_wa = cur_q;
								cnt_wd = cnt_rd + CW'(1);
							end
							if (at_leaf) begin
								fin = 1'b1;
							end else if (lk_b != '0) begin
								rd_en = 1'b1;
								rd_addr = lk_b;
								cur_d = lk_b;
								depth_d = depth_q + DEP_W'(1);
								key_sh_d = key_sh_q << 1;
							end else begin
								par_new_d = 1'b0;
								state_d = S_ALLOC;
							end
						end
					end
					cbt_pkg::OP_DELETE: begin
						if (!pass_q) begin
							// Verify pass.
							if (!at_root && cnt_rd == '0) begin
								fin = 1'b1;
								fin_st = cbt_pkg::ST_ABSENT;
							end else if (at_leaf) begin
								pass_d = 1'b1;
								rd_en = 1'b1;
								cur_d = '0;
								depth_d = '0;
								key_sh_d = key_q;
							end else if (lk_b == '0) begin
								fin = 1'b1;
								fin_st = cbt_pkg::ST_ABSENT;
							end else begin
								rd_en = 1'b1;
								rd_addr = lk_b;
								cur_d = lk_b;
								depth_d = depth_q + DEP_W'(1);
								key_sh_d = key_sh_q << 1;
							end
						end else begin
							// Decrement pass.
							if (!at_root) begin
								cnt_we = 1'b1;
								cnt_wa = cur_q;
								cnt_wd = cnt_rd - CW'(1);
							end
							if (at_leaf) begin
								fin = 1'b1;
							end else begin
								rd_en = 1'b1;
								rd_addr = lk_b;
								cur_d = lk_b;
								depth_d = depth_q + DEP_W'(1);
								key_sh_d = key_sh_q << 1;
							end
						end
					end
					cbt_pkg::OP_QUERY: begin
						nb_d = lk_b;
						if (at_leaf) begin
							fin = 1'b1;
							fin_xor = cbt_pkg::XOR_W'(res_q);
						end else if (lk_nb != '0) begin
							rd_en = 1'b1;
							rd_addr = lk_nb;
							cur_d = lk_nb;
							state_d = S_QWANT;
						end else if (lk_b == '0) begin
							fin = 1'b1;
							fin_st = cbt_pkg::ST_EMPTY;
						end else begin
							rd_en = 1'b1;
							rd_addr = lk_b;
							cur_d = lk_b;
							state_d = S_QB;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_QWANT: begin
				// Opposite-bit child: take it if it still holds values.
				if (cnt_rd != '0) begin
					res_d = (res_q << 1) | KEY_BITS'(1);
					depth_d = depth_q + DEP_W'(1);
					key_sh_d = key_sh_q << 1;
					state_d = S_WALK;
				end else if (nb_q == '0) begin
					fin = 1'b1;
					fin_st = cbt_pkg::ST_EMPTY;
				end else begin
					rd_en = 1'b1;
					rd_addr = nb_q;
					cur_d = nb_q;
					state_d = S_QB;
				end
			end
			S_QB: begin
				// Same-bit child; an unused one under the root means empty.
				if (at_root && cnt_rd == '0) begin
					fin = 1'b1;
					fin_st = cbt_pkg::ST_EMPTY;
				end else begin
					res_d = res_q << 1;
					depth_d = depth_q + DEP_W'(1);
					key_sh_d = key_sh_q << 1;
					state_d = S_WALK;
				end
			end
			S_ALLOC: begin
				// Link a fresh node under the parent and give it count one.
				if (bit_k) begin
					c1_we = 1'b1; c1_wa = cur_q; c1_wd = new_node;
					c0_we = par_new_q; c0_wa = cur_q;
				end else begin
					c0_we = 1'b1; c0_wa = cur_q; c0_wd = new_node;
					c1_we = par_new_q; c1_wa = cur_q;
				end
				cnt_we = 1'b1;
				cnt_wa = new_node;
				cnt_wd = CW'(1);
				used_d = used_q + USED_W'(1);
				cur_d = new_node;
				par_new_d = 1'b1;
				depth_d = depth_q + DEP_W'(1);
				key_sh_d = key_sh_q << 1;
				if (depth_q == DEP_W'(KEY_BITS - 1)) begin
					fin = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = S_IDLE;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			used_q      <= USED_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			used_q      <= used_d;
			out_valid_q <= fin || (out_valid_q && !m_tready);
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		pass_q    <= pass_d;
		op_q      <= op_d;
		key_q     <= key_d;
		key_sh_q  <= key_sh_d;
		res_q     <= res_d;
		depth_q   <= depth_d;
		cur_q     <= cur_d;
		nb_q      <= nb_d;
		par_new_q <= par_new_d;
		if (fin) begin
			out_xor_q <= fin_xor;
			out_st_q  <= fin_st;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_st_q, out_xor_q};

endmodule

// ===== design/counted_binary_trie_max_xor.sv =====
// Top level of the counted binary trie with maximum-XOR query.
// Instantiates cbt_front and cbt_engine; uses cbt_pkg.
//
// Usage: each input transaction on the s_ group carries one operation
// (insert, delete, max-XOR query, clear) and a key. Each produces exactly one
// result transaction on the m_ group with the best XOR and a status code.
// Items queue in a two-entry buffer, so the sender may run ahead of the engine.
// The engine walks the trie one level per cycle for insert and delete,
// through a single registered read port of the node memories.
// Insert makes a check walk, then an update walk that adds missing nodes;
// delete makes a verify walk, then a decrement walk; query tries the
// opposite-bit child at each level, then the same-bit child where that one is
// absent or empty; clear writes the empty root. One item is processed at a time.
// The result waits in an output register; a stalled receiver holds it and
// the engine does not start the next item until that register frees, while
// the input queue keeps accepting until full.
// Reset: after arst_n rises the engine spends one cycle writing the empty
// root, then accepts work. Node memory contents are otherwise not cleared.
module counted_binary_trie_max_xor #(
	parameter int NODE_POOL = 32768,
	parameter int KEY_BITS  = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // op[1:0], key_value[32:2], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // best_xor[30:0], status[32:31], zero pad
);

	logic           q_valid;
	logic           q_pop;
	cbt_pkg::item_t q_item;

	// Input queue.
	cbt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	// Trie engine and result register.
	cbt_engine #(
		.NODE_POOL (NODE_POOL),
		.KEY_BITS  (KEY_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== design/cbt_checker.sv =====
// Port-level checker for counted_binary_trie_max_xor, with its bind.
// Uses cbt_pkg for the status codes.
module cbt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	logic [2:0] pending_q;
	logic       s_xfer, m_xfer;

	assign s_xfer = s_tvalid && s_tready;
	assign m_xfer = m_tvalid && m_tready;

	// Items accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else begin
			pending_q <= pending_q + {2'd0, s_xfer} - {2'd0, m_xfer};
		end
	end

	// A stalled result keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Every result answers an earlier transaction.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 3'd0)
		else $error("result without a pending item");

	// A result with a status other than OK carries a zero XOR.
	a_xor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[32:31] != cbt_pkg::ST_OK |-> m_tdata[30:0] == '0)
		else $error("refused item carries a nonzero XOR");

	// No more than four items in flight.
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("too many items in flight");

endmodule

bind counted_binary_trie_max_xor cbt_checker u_cbt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
